// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the point transform engine RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define PTE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("point transform engine: assertion failed");

// Checked at every rising edge, reset included.
`define PTE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("point transform engine: assertion failed");

`endif

// ----- rtl/pte_pkg.sv -----
// Shared types, constants and helpers of the point transform engine.
// No dependencies; imported by every module of the block.
package pte_pkg;

    localparam int NCOORD       = 4;
    localparam int COORD_W      = 32;
    localparam int DEF_DIMS     = 4;
    localparam int DEF_MAX_PTS  = 1024;
    localparam int QUEUE_DEPTH  = 2;
    localparam int SAT_W        = 52;
    localparam int FRAC_BITS    = 16;

    localparam logic [1:0] REQ_TRANSFORM  = 2'd0;
    localparam logic [1:0] REQ_ACCUMULATE = 2'd1;
    localparam logic [1:0] REQ_CENTROID   = 2'd2;

    localparam logic [1:0] MODE_TRANSLATE = 2'd0;
    localparam logic [1:0] MODE_SCALE     = 2'd1;
    localparam logic [1:0] MODE_ROTATE    = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_PLANE = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_COEF_A = 3'd1;
    localparam logic [2:0] REG_COEF_B = 3'd2;
    localparam logic [2:0] REG_AXES   = 3'd3;
    localparam logic [2:0] REG_OFF_0  = 3'd4;
    localparam logic [2:0] REG_OFF_1  = 3'd5;
    localparam logic [2:0] REG_OFF_2  = 3'd6;
    localparam logic [2:0] REG_OFF_3  = 3'd7;

    typedef enum logic [2:0] {
        K_TRANSLATE,
        K_SCALE,
        K_ROTATE,
        K_BAD_PLANE,
        K_ECHO,
        K_ACCUM,
        K_CENTROID,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind                         kind;
        logic [NCOORD-1:0][COORD_W-1:0] coord;
    } t_item;

    typedef struct packed {
        logic [1:0]                     mode;
        logic [COORD_W-1:0]             coef_a;
        logic [COORD_W-1:0]             coef_b;
        logic [3:0]                     plane_axes;
        logic [NCOORD-1:0][COORD_W-1:0] offset;
    } t_cfg;

    function automatic logic [COORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'(64'sh7FFF_FFFF);
        lo = -SAT_W'(64'sh8000_0000);
        if (v > hi) begin
            return 32'h7FFF_FFFF;
        end else if (v < lo) begin
            return 32'h8000_0000;
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

// ----- rtl/pte_front.sv -----
// Front stage: takes input words and classifies them by request and mode.
// Depends on pte_pkg.
module pte_front #(
    parameter int DIMENSIONS = pte_pkg::DEF_DIMS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_req_type,
    input  logic [pte_pkg::NCOORD-1:0][pte_pkg::COORD_W-1:0] i_coord,
    input  pte_pkg::t_cfg         i_cfg,
    output logic                  o_push_valid,
    input  logic                  i_push_ready,
    output pte_pkg::t_item        o_push_item
);
    import pte_pkg::*;

    logic       r_valid;
    t_item      r_item;
    t_kind      kind;
    logic [1:0] ai;
    logic [1:0] aj;
    logic       plane_ok;

    assign ai       = i_cfg.plane_axes[1:0];
    assign aj       = i_cfg.plane_axes[3:2];
    assign plane_ok = (ai != aj) && (int'(ai) < DIMENSIONS) && (int'(aj) < DIMENSIONS);

    always_comb begin
        unique case (i_req_type)
            REQ_TRANSFORM: begin
                unique case (i_cfg.mode)
                    MODE_TRANSLATE: kind = K_TRANSLATE;
                    MODE_SCALE:     kind = K_SCALE;
                    MODE_ROTATE:    kind = plane_ok ? K_ROTATE : K_BAD_PLANE;
                    default:        kind = K_ECHO;
                endcase
            end
            REQ_ACCUMULATE: kind = K_ACCUM;
            REQ_CENTROID:   kind = K_CENTROID;
            default:        kind = K_NOP;
        endcase
    end

    assign o_in_ready   = !r_valid || i_push_ready;
    assign o_push_valid = r_valid;
    assign o_push_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_item.kind  <= kind;
            r_item.coord <= i_coord;
        end
    end

endmodule

// ----- rtl/pte_queue.sv -----
// Two-entry queue of classified words between the front and back stages.
// Depends on pte_pkg.
module pte_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  pte_pkg::t_item i_push_item,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output pte_pkg::t_item o_pop_item
);
    import pte_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [PTR_W:0]     r_fill;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_fill != (PTR_W+1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign o_pop_item   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_fill <= r_fill + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
        end
        if (push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

endmodule

// ----- rtl/pte_back.sv -----
// Back stage: carries out transforms, accumulation and centroid division.
// Depends on pte_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pte_back #(
    parameter int DIMENSIONS = pte_pkg::DEF_DIMS,
    parameter int MAX_POINTS = pte_pkg::DEF_MAX_PTS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pte_pkg::t_cfg  i_cfg,
    input  logic           i_pop_valid,
    output logic           o_pop_ready,
    input  pte_pkg::t_item i_pop_item,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [pte_pkg::NCOORD-1:0][pte_pkg::COORD_W-1:0] o_res,
    output logic [1:0]     o_status
);
    import pte_pkg::*;

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int SUM_W  = COORD_W + CNT_W;
    localparam int ITER_W = $clog2(SUM_W);
    localparam int X_W    = COORD_W + 1;
    localparam int PROD_W = X_W + COORD_W;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} t_state;

    t_state                    r_state;
    t_item                     r_item;
    logic signed [X_W-1:0]     r_x    [NCOORD];
    logic signed [PROD_W-1:0]  r_p    [NCOORD];
    logic [1:0]                r_step;
    logic signed [SUM_W-1:0]   r_sum  [DIMENSIONS];
    logic [SUM_W-1:0]          r_dq   [DIMENSIONS];
    logic [CNT_W-1:0]          r_rem  [DIMENSIONS];
    logic                      r_neg  [DIMENSIONS];
    logic [ITER_W-1:0]         r_iter;
    logic [CNT_W-1:0]          r_count;
    logic                      r_out_valid;
    logic [NCOORD-1:0][COORD_W-1:0] r_res;
    logic [1:0]                r_status;

    logic                      out_free;
    logic [1:0]                ai;
    logic [1:0]                aj;
    logic signed [X_W-1:0]     mul_x;
    logic signed [COORD_W-1:0] mul_c;
    logic signed [PROD_W-1:0]  prod;
    logic [1:0]                last_step;
    logic signed [PROD_W:0]    rot_n1;
    logic signed [PROD_W:0]    rot_n2;
    logic [NCOORD-1:0][COORD_W-1:0] fin_res;
    logic [1:0]                fin_status;
    logic                      full;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_pop_ready = (r_state == S_IDLE);
    assign ai          = i_cfg.plane_axes[1:0];
    assign aj          = i_cfg.plane_axes[3:2];
    assign full        = (r_count >= CNT_W'(MAX_POINTS));

    // Shared multiplier: one product per cycle.
    assign mul_x = (r_item.kind == K_ROTATE) ? r_x[r_step[0] ? aj : ai] : r_x[r_step];
    assign mul_c = ((r_item.kind == K_ROTATE) && (r_step == 2'd1 || r_step == 2'd2))
                 ? $signed(i_cfg.coef_b) : $signed(i_cfg.coef_a);
    assign prod  = mul_x * mul_c;
    assign last_step = (r_item.kind == K_ROTATE) ? 2'd3 : 2'(DIMENSIONS - 1);

    assign rot_n1 = (PROD_W+1)'(r_p[0]) - (PROD_W+1)'(r_p[1]);
    assign rot_n2 = (PROD_W+1)'(r_p[2]) + (PROD_W+1)'(r_p[3]);

    always_comb begin
        fin_res    = '0;
        fin_status = ST_OK;
        for (int d = 0; d < NCOORD; d++) begin
            if (d < DIMENSIONS) begin
                unique case (r_item.kind)
                    K_TRANSLATE: fin_res[d] = sat32(SAT_W'($signed(r_item.coord[d]))
                                                  + SAT_W'($signed(i_cfg.offset[d])));
                    K_SCALE:     fin_res[d] = sat32(SAT_W'(r_p[d] >>> FRAC_BITS)
                                                  + SAT_W'($signed(i_cfg.offset[d])));
                    K_ROTATE: begin
                        if (2'(d) == ai) begin
                            fin_res[d] = sat32(SAT_W'(rot_n1 >>> FRAC_BITS)
                                             + SAT_W'($signed(i_cfg.offset[d])));
                        end else if (2'(d) == aj) begin
                            fin_res[d] = sat32(SAT_W'(rot_n2 >>> FRAC_BITS)
                                             + SAT_W'($signed(i_cfg.offset[d])));
                        end else begin
                            fin_res[d] = r_item.coord[d];
                        end
                    end
                    K_BAD_PLANE, K_ECHO: fin_res[d] = r_item.coord[d];
                    K_CENTROID: fin_res[d] = r_neg[d] ? COORD_W'(-r_dq[d])
                                                      : r_dq[d][COORD_W-1:0];
                    default: fin_res[d] = '0;
                endcase
            end
        end
        unique case (r_item.kind)
            K_BAD_PLANE: fin_status = ST_BAD_PLANE;
            K_ACCUM:     fin_status = full ? ST_FULL : ST_OK;
            K_CENTROID:  fin_status = (r_count == '0) ? ST_EMPTY : ST_OK;
            default:     fin_status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            for (int d = 0; d < DIMENSIONS; d++) begin
                r_sum[d] <= '0;
            end
        end else begin
            // A result leaving while the next is loaded keeps the valid high.
            if (r_out_valid && i_out_ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_pop_valid) begin
                        r_item <= i_pop_item;
                        r_step <= '0;
                        r_iter <= ITER_W'(SUM_W - 1);
                        for (int d = 0; d < NCOORD; d++) begin
                            r_x[d] <= X_W'($signed(i_pop_item.coord[d]))
                                    - X_W'($signed(i_cfg.offset[d]));
                        end
                        for (int d = 0; d < DIMENSIONS; d++) begin
                            r_neg[d] <= r_sum[d][SUM_W-1];
                            r_dq[d]  <= r_sum[d][SUM_W-1] ? SUM_W'(-r_sum[d]) : r_sum[d];
                            r_rem[d] <= '0;
                        end
                        if (i_pop_item.kind == K_SCALE || i_pop_item.kind == K_ROTATE) begin
                            r_state <= S_MUL;
                        end else if (i_pop_item.kind == K_CENTROID && r_count != '0) begin
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_MUL: begin
                    r_p[r_step] <= prod;
                    r_step      <= r_step + 1'b1;
                    if (r_step == last_step) begin
                        r_state <= S_FIN;
                    end
                end
                S_DIV: begin
                    // Restoring division, one quotient bit per lane per cycle.
                    for (int d = 0; d < DIMENSIONS; d++) begin
                        logic [CNT_W:0] trial;
                        trial = {r_rem[d], r_dq[d][SUM_W-1]};
                        if (trial >= {1'b0, r_count}) begin
                            r_rem[d] <= CNT_W'(trial - {1'b0, r_count});
                            r_dq[d]  <= {r_dq[d][SUM_W-2:0], 1'b1};
                        end else begin
                            r_rem[d] <= trial[CNT_W-1:0];
                            r_dq[d]  <= {r_dq[d][SUM_W-2:0], 1'b0};
                        end
                    end
                    r_iter <= r_iter - 1'b1;
                    if (r_iter == '0) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_res       <= fin_res;
                        r_status    <= fin_status;
                        r_state     <= S_IDLE;
                        if (r_item.kind == K_CENTROID) begin
                            if (r_count != '0) begin
                                r_count <= '0;
                                for (int d = 0; d < DIMENSIONS; d++) begin
                                    r_sum[d] <= '0;
                                end
                            end
                        end else if (r_item.kind == K_ACCUM && !full) begin
                            r_count <= r_count + 1'b1;
                            for (int d = 0; d < DIMENSIONS; d++) begin
                                r_sum[d] <= r_sum[d] + SUM_W'($signed(r_item.coord[d]));
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;
    assign o_status    = r_status;

    `PTE_ASSERT(a_count_bounded, i_clk, i_rst_n, r_count <= CNT_W'(MAX_POINTS))
    `PTE_ASSERT(a_div_nonzero, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_count != '0))
    `PTE_ASSERT(a_fin_loads, i_clk, i_rst_n, (r_state == S_FIN && out_free) |=> r_out_valid)
    `PTE_ASSERT(a_pop_only_idle, i_clk, i_rst_n,
        (r_state != S_IDLE) |=> (r_state != S_IDLE || $past(r_state) == S_FIN
                                 || $past(r_state) == S_IDLE))
endmodule

// ----- rtl/point_transform_engine.sv -----
// Point transform engine. Each accepted word is one 4-D Q16.16 point with a request
// type: transform (translate, scale about the offset, or plane rotation about it),
// accumulate into running sums, or read and clear the centroid. Every word gives
// exactly one result word. A front stage takes and classifies words into a two-entry
// queue; a back stage executes them one at a time using a single shared 33x32
// multiplier. Translate, echo, accumulate and empty-centroid words go straight to the
// final back-stage state; scale forms DIMENSIONS multiplier products and rotation four,
// one at a time. A non-empty centroid read runs a restoring divider, all lanes in
// parallel. Configuration writes are always taken and must only be issued while the
// block is idle. Depends on pte_pkg, pte_front, pte_queue and pte_back.
module point_transform_engine #(
    parameter int DIMENSIONS = pte_pkg::DEF_DIMS,
    parameter int MAX_POINTS = pte_pkg::DEF_MAX_PTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_coord_0,
    input  logic [31:0] i_coord_1,
    input  logic [31:0] i_coord_2,
    input  logic [31:0] i_coord_3,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_res_0,
    output logic [31:0] o_res_1,
    output logic [31:0] o_res_2,
    output logic [31:0] o_res_3,
    output logic [1:0]  o_status
);
    import pte_pkg::*;

    // Configuration registers, written one word at a time.
    t_cfg  r_cfg;
    logic  push_valid;
    logic  push_ready;
    t_item push_item;
    logic  pop_valid;
    logic  pop_ready;
    t_item pop_item;
    logic [NCOORD-1:0][COORD_W-1:0] coord;
    logic [NCOORD-1:0][COORD_W-1:0] res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode       <= MODE_TRANSLATE;
            r_cfg.coef_a     <= 32'h0001_0000;
            r_cfg.coef_b     <= '0;
            r_cfg.plane_axes <= 4'd4;
            r_cfg.offset     <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MODE:   r_cfg.mode       <= i_cfg_data[1:0];
                REG_COEF_A: r_cfg.coef_a     <= i_cfg_data;
                REG_COEF_B: r_cfg.coef_b     <= i_cfg_data;
                REG_AXES:   r_cfg.plane_axes <= i_cfg_data[3:0];
                REG_OFF_0:  r_cfg.offset[0]  <= i_cfg_data;
                REG_OFF_1:  r_cfg.offset[1]  <= i_cfg_data;
                REG_OFF_2:  r_cfg.offset[2]  <= i_cfg_data;
                REG_OFF_3:  r_cfg.offset[3]  <= i_cfg_data;
                default:    r_cfg.mode       <= r_cfg.mode;
            endcase
        end
    end

    assign coord = {i_coord_3, i_coord_2, i_coord_1, i_coord_0};

    pte_front #(.DIMENSIONS(DIMENSIONS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_coord      (coord),
        .i_cfg        (r_cfg),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_item  (push_item)
    );

    pte_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_item   (pop_item)
    );

    pte_back #(.DIMENSIONS(DIMENSIONS), .MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_pop_valid  (pop_valid),
        .o_pop_ready  (pop_ready),
        .i_pop_item   (pop_item),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_res        (res),
        .o_status     (o_status)
    );

    assign o_res_0 = res[0];
    assign o_res_1 = res[1];
    assign o_res_2 = res[2];
    assign o_res_3 = res[3];

endmodule

// ----- tb/point_transform_engine_test.sv -----
// Self-checking testbench of the point transform engine: directed and random words.
// Predicts every result in a scoreboard class; depends on pte_pkg and the RTL only.
`timescale 1ns / 1ps

import pte_pkg::*;

typedef struct {
    logic [31:0] res [4];
    logic [1:0]  status;
} t_point_result;

class point_scoreboard;
    // Copy of the configuration and of the centroid state.
    logic [1:0]         mode;
    longint             coef_a, coef_b;
    logic [3:0]         axes;
    longint             offset [4];
    longint             sums [4];
    int                 count;
    t_point_result      pending [$];
    int                 errors;

    function new();
        mode = MODE_TRANSLATE;
        coef_a = 65536;
        coef_b = 0;
        axes = 4'd4;
        for (int d = 0; d < 4; d++) begin
            offset[d] = 0;
            sums[d] = 0;
        end
        count = 0;
        errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
        case (idx)
            REG_MODE:   mode = data[1:0];
            REG_COEF_A: coef_a = longint'($signed(data));
            REG_COEF_B: coef_b = longint'($signed(data));
            REG_AXES:   axes = data[3:0];
            default:    offset[idx - REG_OFF_0] = longint'($signed(data));
        endcase
    endfunction

    static function longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Floor of (p1 - p2) / 2^16, formed at 66 bits so nothing overflows.
    static function longint floor_shift_diff(longint p1, longint p2);
        logic signed [65:0] w;
        w = 66'(p1) - 66'(p2);
        w = w >>> 16;
        return longint'(w);
    endfunction

    function void note_word(logic [1:0] req, logic [31:0] c [4]);
        t_point_result r;
        longint p [4];
        longint x1, x2;
        int ai, aj;
        for (int d = 0; d < 4; d++) begin
            p[d] = longint'($signed(c[d]));
            r.res[d] = '0;
        end
        r.status = ST_OK;
        if (req == REQ_TRANSFORM) begin
            for (int d = 0; d < 4; d++) r.res[d] = c[d];
            if (mode == MODE_TRANSLATE) begin
                for (int d = 0; d < 4; d++) r.res[d] = 32'(clamp32(p[d] + offset[d]));
            end else if (mode == MODE_SCALE) begin
                for (int d = 0; d < 4; d++)
                    r.res[d] = 32'(clamp32(floor_shift_diff(coef_a * (p[d] - offset[d]), 0)
                                           + offset[d]));
            end else if (mode == MODE_ROTATE) begin
                ai = axes[1:0];
                aj = axes[3:2];
                if (ai == aj) begin
                    r.status = ST_BAD_PLANE;
                end else begin
                    x1 = p[ai] - offset[ai];
                    x2 = p[aj] - offset[aj];
                    r.res[ai] = 32'(clamp32(floor_shift_diff(x1 * coef_a, x2 * coef_b)
                                            + offset[ai]));
                    r.res[aj] = 32'(clamp32(floor_shift_diff(x1 * coef_b, -(x2 * coef_a))
                                            + offset[aj]));
                end
            end
        end else if (req == REQ_ACCUMULATE) begin
            if (count >= 1024) begin
                r.status = ST_FULL;
            end else begin
                for (int d = 0; d < 4; d++) sums[d] += p[d];
                count++;
            end
        end else if (req == REQ_CENTROID) begin
            if (count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                // SystemVerilog division truncates toward zero, as required.
                for (int d = 0; d < 4; d++) begin
                    r.res[d] = 32'(sums[d] / longint'(count));
                    sums[d] = 0;
                end
                count = 0;
            end
        end
        pending.push_back(r);
    endfunction

    function void check_word(logic [31:0] got [4], logic [1:0] st);
        t_point_result e;
        if (pending.size() == 0) begin
            $display("%0t: result word with none expected", $time);
            errors++;
            return;
        end
        e = pending.pop_front();
        for (int d = 0; d < 4; d++)
            if (got[d] !== e.res[d]) begin
                $display("%0t: res_%0d expected %h actual %h", $time, d, e.res[d], got[d]);
                errors++;
            end
        if (st !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, st);
            errors++;
        end
    endfunction
endclass

module point_transform_engine_test;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_req_type = '0;
    logic [31:0] i_coord_0 = '0, i_coord_1 = '0, i_coord_2 = '0, i_coord_3 = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_res_0, o_res_1, o_res_2, o_res_3;
    logic [1:0]  o_status;

    point_scoreboard centroid_board = new();
    bit  input_done = 1'b0;
    int  idle_cycles = 0;

    point_transform_engine uut (.*);

    // 2 ns clock period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The watchdog counts cycles in which no word moves on any channel; a long
    // centroid division is far below the limit.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("point_transform_engine_test failed");
            $finish;
        end
    end

    // Result side: a random stall before each word, often none at all.
    initial begin : result_sink
        logic [31:0] got [4];
        int stall;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk iff o_out_valid);
            got = '{o_res_0, o_res_1, o_res_2, o_res_3};
            centroid_board.check_word(got, o_status);
        end
    end

    // The configuration valid goes low after every register write.
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk iff o_cfg_ready);
        centroid_board.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drops the input valid, waits for every expected word, then for the
    // longest back-stage latency.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (centroid_board.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic send_word(logic [1:0] req, logic [31:0] c [4], bit gap);
        int wait_cycles;
        wait_cycles = gap ? $urandom_range(0, 7) : 0;
        if (wait_cycles != 0) begin
            i_in_valid <= 1'b0;
            repeat (wait_cycles) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_coord_0 <= c[0];
        i_coord_1 <= c[1];
        i_coord_2 <= c[2];
        i_coord_3 <= c[3];
        @(posedge i_clk iff o_in_ready);
        centroid_board.note_word(req, c);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 1 << 20))
                                           : -32'($urandom_range(0, 1 << 20));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(0, 131072)) - 32'd65536;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_settings(bit extreme);
        write_reg(REG_MODE, 32'($urandom_range(0, 3)));
        write_reg(REG_COEF_A, extreme ? 32'h8000_0000 : rand_coef());
        write_reg(REG_COEF_B, extreme ? 32'h7FFF_FFFF : rand_coef());
        write_reg(REG_AXES, 32'($urandom_range(0, 15)));
        for (int d = 0; d < 4; d++)
            write_reg(REG_OFF_0 + 3'(d), extreme ? 32'h7FFF_FFFF : rand_coord());
    endtask

    initial begin : stimulus
        logic [31:0] c [4];
        logic [31:0] top [4];
        logic [31:0] bottom [4];
        logic [1:0] req;
        int n;
        bit gaps;
        top = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        bottom = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under reset settings: empty centroid, identity
        // translate, accumulate at both extremes, centroid and unused request.
        send_word(REQ_CENTROID, top, 1'b0);
        send_word(REQ_TRANSFORM, top, 1'b0);
        send_word(REQ_ACCUMULATE, top, 1'b0);
        send_word(REQ_ACCUMULATE, bottom, 1'b0);
        send_word(REQ_ACCUMULATE, bottom, 1'b0);
        send_word(REQ_CENTROID, top, 1'b0);
        send_word(2'd3, top, 1'b0);
        drain();
        // Saturating translate, scale and rotation, and the unused mode, with extreme settings.
        random_settings(1'b1);
        for (int m = 0; m < 4; m++) begin
            write_reg(REG_MODE, 32'(m));
            send_word(REQ_TRANSFORM, top, 1'b0);
            send_word(REQ_TRANSFORM, bottom, 1'b0);
            drain();
        end
        // A bad plane with equal axes, then a good one.
        write_reg(REG_MODE, 32'(MODE_ROTATE));
        write_reg(REG_AXES, 32'd5);
        send_word(REQ_TRANSFORM, top, 1'b0);
        drain();
        write_reg(REG_AXES, 32'd14);
        send_word(REQ_TRANSFORM, bottom, 1'b0);
        drain();

        // Accumulator full: 1025 accumulates, the last one dropped.
        for (int i = 0; i < 1025; i++) begin
            foreach (c[d]) c[d] = $urandom;
            send_word(REQ_ACCUMULATE, c, 1'b0);
        end
        send_word(REQ_CENTROID, top, 1'b0);
        drain();

        // Random phases, each under fresh settings; mostly transforms, with accumulates,
        // centroid reads and unused requests mixed in at random.
        for (int phase = 0; phase < 24; phase++) begin
            random_settings(1'b0);
            gaps = (phase % 3) != 0;
            n = 0;
            while (n < 25) begin
                foreach (c[d]) c[d] = rand_coord();
                case ($urandom_range(0, 19))
                    0, 1, 2, 3: req = REQ_ACCUMULATE;
                    4:          req = REQ_CENTROID;
                    5:          req = 2'd3;
                    default:    req = REQ_TRANSFORM;
                endcase
                send_word(req, c, gaps);
                n++;
            end
            drain();
        end
        input_done = 1'b1;

        if (centroid_board.errors == 0) begin
            $display("point_transform_engine_test passed");
        end else begin
            $display("point_transform_engine_test failed");
        end
        $finish;
    end

endmodule
